/* rtl/van_frame_symbol_encoder_core_assert.svh */
// assertion macros shared by the van frame symbol encoder rtl
// no dependencies; files that assert include this header by name
`ifndef VAN_FRAME_SYMBOL_ENCODER_CORE_ASSERT_SVH
`define VAN_FRAME_SYMBOL_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define VFSE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);
// expression must never be true outside reset
`define VFSE_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);
`else
`define VFSE_ASSERT(label, clk, rstn, prop, msg)
`define VFSE_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

/* rtl/vfse_pkg.sv */
// shared types, constants and symbol/crc functions for the van frame encoder
// no dependencies
package vfse_pkg;

    localparam int MaxSyms = 6;

    localparam logic [7:0]  SofByte   = 8'h0E;
    localparam logic [14:0] CrcPoly   = 15'h0F9D;
    localparam logic [14:0] CrcInit   = 15'h7FFF;
    localparam logic [14:0] CrcMask   = 15'h7FFF;
    localparam logic [9:0]  EofSymbol = 10'h3FF;
    localparam logic [3:0]  ComNormal = 4'h8;
    localparam logic [3:0]  ComReply  = 4'hF;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_REPLY = 2'd3
    } cmd_t;

    // one run of symbols caused by a single request
    typedef struct packed {
        logic [MaxSyms-1:0][9:0] sym;
        logic [MaxSyms-1:0]      eof;
        logic [2:0]              cnt;
    } run_t;

    // enrz stuffing: b[7:4], ~b[4], b[3:0], ~b[0]
    function automatic logic [9:0] stuff(input logic [7:0] b);
        return {b[7:4], ~b[4], b[3:0], ~b[0]};
    endfunction

    function automatic logic [14:0] crc_byte(input logic [14:0] crc, input logic [7:0] b);
        logic [14:0] c;
        logic [7:0]  d;
        logic        fb;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            fb = c[14] ^ d[7];
            d  = {d[6:0], 1'b0};
            c  = {c[13:0], 1'b0} ^ (fb ? CrcPoly : 15'h0000);
        end
        return c;
    endfunction

    // clears the lowest set bit of a symbol (end of data violation)
    function automatic logic [9:0] clear_low(input logic [9:0] s);
        return s & (s - 10'd1);
    endfunction

endpackage

/* rtl/vfse_seq.sv */
// symbol sequencer: holds one run of symbols and feeds them to the output register
// depends on vfse_pkg and van_frame_symbol_encoder_core_assert.svh
`include "van_frame_symbol_encoder_core_assert.svh"

module vfse_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ld_i,     // load a new run
    input  vfse_pkg::run_t run_i,
    output logic          rdy_o,    // a run may be loaded this cycle
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,  // symbol[9:0], zero pad
    output logic          m_tuser,  // end_of_frame
    output logic          m_tlast   // last_of_run
);
    import vfse_pkg::*;

    logic       run_valid_reg, run_valid_next;
    run_t       run_reg, run_next;
    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [9:0] m_sym_reg, m_sym_next;
    logic       m_eof_reg, m_eof_next;
    logic       m_last_reg, m_last_next;

    logic out_free;
    logic pop;
    logic at_last;

    assign out_free = !m_valid_reg || m_tready;
    assign pop      = run_valid_reg && out_free;
    assign at_last  = idx_reg == (run_reg.cnt - 3'd1);
    assign rdy_o    = !run_valid_reg || (pop && at_last);

    always_comb begin
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        m_sym_next     = m_sym_reg;
        m_eof_next     = m_eof_reg;
        m_last_next    = m_last_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            m_valid_next = 1'b1;
            m_sym_next   = run_reg.sym[idx_reg];
            m_eof_next   = run_reg.eof[idx_reg];
            m_last_next  = at_last;
            idx_next     = 3'(idx_reg + 3'd1);
            if (at_last) begin
                run_valid_next = 1'b0;
            end
        end
        if (ld_i) begin
            run_valid_next = 1'b1;
            run_next       = run_i;
            idx_next       = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            run_valid_reg <= run_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
        run_reg    <= run_next;
        m_sym_reg  <= m_sym_next;
        m_eof_reg  <= m_eof_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_sym_reg};
    assign m_tuser  = m_eof_reg;
    assign m_tlast  = m_last_reg;

    `VFSE_ASSERT(a_idx_range, aclk, aresetn, run_valid_reg |-> (idx_reg < run_reg.cnt), "symbol index past end of run")
    `VFSE_NEVER(a_load_busy, aclk, aresetn, ld_i && !rdy_o, "run loaded while previous run still pending")
    `VFSE_ASSERT(a_eof_last, aclk, aresetn, (m_valid_reg && m_eof_reg) |-> m_last_reg, "eof symbol not last of its run")
    `VFSE_ASSERT(a_eof_sym, aclk, aresetn, (m_valid_reg && m_eof_reg) |-> (m_sym_reg == EofSymbol), "eof flag on a non-eof symbol")

endmodule

/* rtl/van_frame_symbol_encoder_core.sv */
// top level of the van bus frame symbol encoder
// depends on vfse_pkg and vfse_seq
//
//  channel | dir | tdata                                   | tuser        | tlast
//  s_      | in  | identifier[11:0] require_ack[12] data[20:13] | command[1:0] | -
//  m_      | out | symbol[9:0]                             | end_of_frame | last_of_run
//
// a request is taken in the cycle it arrives when the sequencer holds no pending run;
// its symbols (open 3, data 1, close 3, reply 6, ignored data/close none) then leave
// one per cycle through the output register while m_tready is high; the next request
// is taken in the same cycle as the previous run's last symbol moves out.
// m_tready low stalls the sequencer.
// reset (aresetn low, synchronous) restores crc 0x7fff, no open frame, no pending run
module van_frame_symbol_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // identifier[11:0], require_ack[12], data_byte[20:13], pad
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // symbol[9:0], pad
    output logic        m_tuser,   // end_of_frame
    output logic        m_tlast    // last_of_run
);
    import vfse_pkg::*;

    // running crc and frame state
    logic [14:0] crc_reg, crc_next;
    logic        in_frame_reg, in_frame_next;

    // request fields
    cmd_t        cmd;
    logic [11:0] ident;
    logic        ack;
    logic [7:0]  data;

    // header and trailer pieces
    logic [7:0]  id_hi;
    logic [7:0]  com;
    logic [14:0] hdr_crc;
    logic [14:0] trl_src;
    logic [15:0] crc16;

    logic [9:0]  trl_hi;
    logic [9:0]  trl_lo;

    logic        accept;
    logic        ld;
    run_t        run;
    logic        seq_rdy;

    assign cmd   = cmd_t'(s_tuser);
    assign ident = s_tdata[11:0];
    assign ack   = s_tdata[12];
    assign data  = s_tdata[20:13];

    assign accept = s_tvalid && s_tready;

    // com low nibble: ack-request layout for open, all ones for reply-request
    assign id_hi   = ident[11:4];
    assign com     = {ident[3:0], (cmd == CMD_REPLY) ? ComReply : (ComNormal | {1'b0, ack, 2'b00})};
    assign hdr_crc = crc_byte(crc_byte(CrcInit, id_hi), com);

    // trailer of close uses running crc, reply-request uses the fresh header crc
    assign trl_src = (cmd == CMD_REPLY) ? hdr_crc : crc_reg;
    assign crc16   = {trl_src ^ CrcMask, 1'b0};
    assign trl_hi  = stuff(crc16[15:8]);
    assign trl_lo  = clear_low(stuff(crc16[7:0]));

    always_comb begin
        run           = '0;
        ld            = 1'b0;
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;

        case (cmd)
            CMD_OPEN: begin
                run.sym[0]    = stuff(SofByte);
                run.sym[1]    = stuff(id_hi);
                run.sym[2]    = stuff(com);
                run.cnt       = 3'd3;
                ld            = 1'b1;
                crc_next      = hdr_crc;
                in_frame_next = 1'b1;
            end
            CMD_DATA: begin
                run.sym[0] = stuff(data);
                run.cnt    = 3'd1;
                if (in_frame_reg) begin
                    ld       = 1'b1;
                    crc_next = crc_byte(crc_reg, data);
                end
            end
            CMD_CLOSE: begin
                run.sym[0] = trl_hi;
                run.sym[1] = trl_lo;
                run.sym[2] = EofSymbol;
                run.eof[2] = 1'b1;
                run.cnt    = 3'd3;
                if (in_frame_reg) begin
                    ld            = 1'b1;
                    in_frame_next = 1'b0;
                end
            end
            CMD_REPLY: begin
                run.sym[0]    = stuff(SofByte);
                run.sym[1]    = stuff(id_hi);
                run.sym[2]    = stuff(com);
                run.sym[3]    = trl_hi;
                run.sym[4]    = trl_lo;
                run.sym[5]    = EofSymbol;
                run.eof[5]    = 1'b1;
                run.cnt       = 3'd6;
                ld            = 1'b1;
                crc_next      = hdr_crc;
                in_frame_next = 1'b0;
            end
            default: begin
                ld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CrcInit;
            in_frame_reg <= 1'b0;
        end else if (accept) begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

    // sequencer owns the run buffer and the output register
    vfse_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_i     (accept && ld),
        .run_i    (run),
        .rdy_o    (seq_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign s_tready = seq_rdy;

endmodule
